FILE: hdl/egm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egm_pkg
// Shared widths, register indexes and command types for the ElGamal core.
// ----------------------------------------------------------------------------
package egm_pkg;

	localparam int unsigned MOD_W = 31;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_MODULUS = 3'd0;
	localparam logic [IDX_W-1:0] REG_GENERATOR = 3'd1;
	localparam logic [IDX_W-1:0] REG_PUBLIC_KEY = 3'd2;
	localparam logic [IDX_W-1:0] REG_PRIVATE_KEY = 3'd3;
	localparam logic [IDX_W-1:0] REG_EPHEMERAL = 3'd4;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// multiplier handshake
	typedef struct packed {
		logic start;
		logic [MOD_W-1:0] u;
		logic [MOD_W-1:0] v;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [MOD_W-1:0] prod;
	} mul_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_RED_WAIT,
		ST_POW_INIT,
		ST_POW_BIT,
		ST_POW_MUL_R,
		ST_POW_WAIT_R,
		ST_POW_SQ,
		ST_POW_WAIT_SQ,
		ST_POW_NEXT,
		ST_AFTER_POW,
		ST_FINAL_MUL,
		ST_FINAL_WAIT,
		ST_OUT
	} state_t;

endpackage

FILE: hdl/egm_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egm_mulmod
// Bit-serial modular multiplier: (u * v) mod p, one bit of v per cycle.
// ----------------------------------------------------------------------------
module egm_mulmod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [egm_pkg::MOD_W-1:0]    modulus,
	input  egm_pkg::mul_req_t            req,
	output egm_pkg::mul_rsp_t            rsp
);

	logic [egm_pkg::MOD_W-1:0] u_q;
	logic [egm_pkg::MOD_W-1:0] v_q;
	logic [egm_pkg::MOD_W-1:0] acc_q;
	logic                      busy_q;
	logic                      done_q;

	logic [egm_pkg::MOD_W:0]   acc_sum;
	logic [egm_pkg::MOD_W:0]   u_dbl;
	logic [egm_pkg::MOD_W-1:0] acc_nxt;
	logic [egm_pkg::MOD_W-1:0] u_nxt;

	// operands are below p, so one conditional subtract keeps them reduced
	always_comb begin
		acc_sum = {1'b0, acc_q} + {1'b0, u_q};
		u_dbl   = {u_q, 1'b0};
		if (acc_sum >= {1'b0, modulus}) begin
			acc_nxt = egm_pkg::MOD_W'(acc_sum - {1'b0, modulus});
		end else begin
			acc_nxt = acc_sum[egm_pkg::MOD_W-1:0];
		end
		if (u_dbl >= {1'b0, modulus}) begin
			u_nxt = egm_pkg::MOD_W'(u_dbl - {1'b0, modulus});
		end else begin
			u_nxt = u_dbl[egm_pkg::MOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && v_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			u_q   <= req.u;
			v_q   <= req.v;
			acc_q <= '0;
		end else if (busy_q && v_q != '0) begin
			if (v_q[0]) begin
				acc_q <= acc_nxt;
			end
			u_q <= u_nxt;
			v_q <= v_q >> 1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q))
		else $error("product done without a running multiply");
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && modulus != '0 && $stable(modulus)) |=> (acc_q < modulus || !busy_q))
		else $error("accumulator left the field");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("multiplier did not start");

endmodule

FILE: hdl/elgamal_modexp_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgamal_modexp_cipher_core
// ElGamal encrypt / decrypt over GF(p) with bit-serial modular arithmetic.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  in       | in_valid/in_ready, operation, plain_byte,      | sink
//           | cipher_a, cipher_b                             |
//  out      | out_valid/out_ready, out_a, out_b, out_plain   | source
//  cfg      | cfg_we, cfg_index, cfg_data                    | sink
//
// One item at a time. A modular product holds the shared serial multiplier
// for a start, one shift per bit of v, an end check and the done strobe.
// Each exponent bit costs up to two products plus the two sequencing states
// POW_BIT and POW_NEXT; an encrypt item is two exponentiations, three
// reductions and a final product, and a decrypt item has two reductions.
// Reset clears control state and loads the register defaults.
// in_ready is high only in idle; a finished result sits in the output
// register until transferred, and the next item is taken no earlier than that transfer.
// ----------------------------------------------------------------------------
module elgamal_modexp_cipher_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [egm_pkg::BYTE_W-1:0]      plain_byte,
	input  logic [egm_pkg::MOD_W-1:0]       cipher_a,
	input  logic [egm_pkg::MOD_W-1:0]       cipher_b,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [egm_pkg::MOD_W-1:0]       out_a,
	output logic [egm_pkg::MOD_W-1:0]       out_b,
	output logic [egm_pkg::BYTE_W-1:0]      out_plain,
	input  logic                            cfg_we,
	input  logic [egm_pkg::IDX_W-1:0]       cfg_index,
	input  logic [egm_pkg::MOD_W-1:0]       cfg_data
);

	// configuration registers
	logic [egm_pkg::MOD_W-1:0] mod_q, gen_q, pub_q, priv_q, eph_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= egm_pkg::MOD_W'(257);
			gen_q  <= egm_pkg::MOD_W'(3);
			pub_q  <= egm_pkg::MOD_W'(1);
			priv_q <= egm_pkg::MOD_W'(1);
			eph_q  <= egm_pkg::MOD_W'(41);
		end else if (cfg_we) begin
			unique case (cfg_index)
				egm_pkg::REG_MODULUS:     mod_q  <= cfg_data;
				egm_pkg::REG_GENERATOR:   gen_q  <= cfg_data;
				egm_pkg::REG_PUBLIC_KEY:  pub_q  <= cfg_data;
				egm_pkg::REG_PRIVATE_KEY: priv_q <= cfg_data;
				egm_pkg::REG_EPHEMERAL:   eph_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Work plan, by phase:
	//  phase 0: reduce operand (g or a) to base via x*1 mod p
	//  phase 1: pow(base, exp) ; enc: exp=k -> a ; dec: exp=x -> ax
	//  phase 2: enc: reduce y ; dec: pow(ax, p-2)
	//  then: enc pow(y, k) ; reduce m or b ; final product (sequencer below)
	// Reduction of any value w mod p: mul_mod(w', 1) needs w' < p, so instead
	// reduce by serial restoring shift: done via multiplier with u = 1 and
	// v = w, which accumulates 2^i mod p over the bits of w.

	egm_pkg::state_t state_q, state_d;
	egm_pkg::mul_req_t mreq;
	egm_pkg::mul_rsp_t mrsp;

	logic                      op_q;
	logic [egm_pkg::BYTE_W-1:0] pb_q;
	logic [egm_pkg::MOD_W-1:0] cb_q;
	logic [egm_pkg::MOD_W-1:0] base_q;     // base of current power
	logic [egm_pkg::MOD_W-1:0] exp_q;      // remaining exponent bits
	logic [egm_pkg::MOD_W-1:0] res_q;      // running power
	logic [egm_pkg::MOD_W-1:0] sav_q;      // saved reduced m or b
	logic [egm_pkg::MOD_W-1:0] red_src_q;  // value to reduce
	logic [2:0]                step_q;     // which job of the item
	logic [egm_pkg::MOD_W-1:0] oa_q, ob_q;
	logic [egm_pkg::BYTE_W-1:0] op8_q;
	logic                      ov_q;
	logic [egm_pkg::MOD_W-1:0] one_p;

	localparam logic [2:0] J_RED1 = 3'd0; // reduce first base
	localparam logic [2:0] J_POW1 = 3'd1;
	localparam logic [2:0] J_RED2 = 3'd2; // enc: reduce y
	localparam logic [2:0] J_POW2 = 3'd3;
	localparam logic [2:0] J_RED3 = 3'd4; // reduce m or b

	assign one_p = (mod_q == egm_pkg::MOD_W'(1)) ? '0 : egm_pkg::MOD_W'(1);

	egm_mulmod u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (mod_q),
		.req     (mreq),
		.rsp     (mrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egm_pkg::ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == egm_pkg::ST_OUT) begin
				ov_q <= 1'b1;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// next state and multiplier requests
	always_comb begin
		state_d = state_q;
		mreq.start = 1'b0;
		mreq.u = '0;
		mreq.v = '0;
		unique case (state_q)
			egm_pkg::ST_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = (mod_q < egm_pkg::MOD_W'(2)) ? egm_pkg::ST_OUT
						: egm_pkg::ST_REDUCE;
				end
			end
			egm_pkg::ST_REDUCE: begin
				// w mod p = sum of bits of w times 2^i mod p; u starts at 1 mod p
				mreq.start = 1'b1;
				mreq.u = one_p;
				mreq.v = red_src_q;
				state_d = egm_pkg::ST_RED_WAIT;
			end
			egm_pkg::ST_RED_WAIT: begin
				if (mrsp.done) begin
					state_d = (step_q == J_RED3) ? egm_pkg::ST_FINAL_MUL
						: egm_pkg::ST_POW_INIT;
				end
			end
			egm_pkg::ST_POW_INIT: state_d = egm_pkg::ST_POW_BIT;
			egm_pkg::ST_POW_BIT: begin
				if (exp_q == '0) begin
					state_d = egm_pkg::ST_AFTER_POW;
				end else if (exp_q[0]) begin
					state_d = egm_pkg::ST_POW_MUL_R;
				end else begin
					state_d = egm_pkg::ST_POW_SQ;
				end
			end
			egm_pkg::ST_POW_MUL_R: begin
				mreq.start = 1'b1;
				mreq.u = res_q;
				mreq.v = base_q;
				state_d = egm_pkg::ST_POW_WAIT_R;
			end
			egm_pkg::ST_POW_WAIT_R: begin
				if (mrsp.done) begin
					state_d = egm_pkg::ST_POW_SQ;
				end
			end
			egm_pkg::ST_POW_SQ: begin
				mreq.start = 1'b1;
				mreq.u = base_q;
				mreq.v = base_q;
				state_d = egm_pkg::ST_POW_WAIT_SQ;
			end
			egm_pkg::ST_POW_WAIT_SQ: begin
				if (mrsp.done) begin
					state_d = egm_pkg::ST_POW_NEXT;
				end
			end
			egm_pkg::ST_POW_NEXT: state_d = egm_pkg::ST_POW_BIT;
			egm_pkg::ST_AFTER_POW: begin
				if (step_q == J_POW1) begin
					state_d = (op_q == egm_pkg::OP_ENCRYPT) ? egm_pkg::ST_REDUCE
						: egm_pkg::ST_POW_INIT;
				end else begin
					state_d = egm_pkg::ST_REDUCE;
				end
			end
			egm_pkg::ST_FINAL_MUL: begin
				mreq.start = 1'b1;
				mreq.u = res_q;
				mreq.v = sav_q;
				state_d = egm_pkg::ST_FINAL_WAIT;
			end
			egm_pkg::ST_FINAL_WAIT: begin
				if (mrsp.done) begin
					state_d = egm_pkg::ST_OUT;
				end
			end
			egm_pkg::ST_OUT: state_d = egm_pkg::ST_IDLE;
			default: state_d = egm_pkg::ST_IDLE;
		endcase
		if (state_q == egm_pkg::ST_IDLE && ov_q && !out_ready) begin
			state_d = egm_pkg::ST_IDLE;
		end
	end

	assign in_ready = (state_q == egm_pkg::ST_IDLE) && (!ov_q || out_ready);

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= J_RED1;
		end else begin
			unique case (state_q)
				egm_pkg::ST_IDLE: begin
					if (in_valid && in_ready) begin
						step_q <= J_RED1;
					end
				end
				egm_pkg::ST_RED_WAIT: begin
					if (mrsp.done && step_q != J_RED3) begin
						step_q <= step_q + 3'd1;
					end
				end
				egm_pkg::ST_AFTER_POW: begin
					if (step_q == J_POW1 && op_q == egm_pkg::OP_DECRYPT) begin
						step_q <= J_POW2;
					end else if (step_q == J_POW1) begin
						step_q <= J_RED2;
					end else begin
						step_q <= J_RED3;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			egm_pkg::ST_IDLE: begin
				if (in_valid && in_ready) begin
					op_q <= operation;
					pb_q <= plain_byte;
					cb_q <= cipher_b;
					red_src_q <= (operation == egm_pkg::OP_ENCRYPT) ? gen_q : cipher_a;
					oa_q <= '0;
					ob_q <= '0;
					op8_q <= '0;
				end
			end
			egm_pkg::ST_RED_WAIT: begin
				if (mrsp.done) begin
					base_q <= mrsp.prod;
					if (step_q == J_RED3) begin
						sav_q <= mrsp.prod;
					end
				end
			end
			egm_pkg::ST_POW_INIT: begin
				res_q <= one_p;
				if (step_q == J_POW2 && op_q == egm_pkg::OP_DECRYPT) begin
					exp_q <= mod_q - egm_pkg::MOD_W'(2);
					base_q <= res_q;
				end else if (step_q == J_POW1) begin
					exp_q <= (op_q == egm_pkg::OP_ENCRYPT) ? eph_q : priv_q;
				end else begin
					exp_q <= eph_q;
				end
			end
			egm_pkg::ST_POW_WAIT_R: begin
				if (mrsp.done) begin
					res_q <= mrsp.prod;
				end
			end
			egm_pkg::ST_POW_WAIT_SQ: begin
				if (mrsp.done) begin
					base_q <= mrsp.prod;
				end
			end
			egm_pkg::ST_POW_NEXT: exp_q <= exp_q >> 1;
			egm_pkg::ST_AFTER_POW: begin
				if (step_q == J_POW1 && op_q == egm_pkg::OP_ENCRYPT) begin
					oa_q <= res_q;
					red_src_q <= pub_q;
				end else if (step_q != J_POW1) begin
					red_src_q <= (op_q == egm_pkg::OP_ENCRYPT)
						? egm_pkg::MOD_W'(pb_q) : cb_q;
				end
			end
			egm_pkg::ST_FINAL_WAIT: begin
				if (mrsp.done) begin
					if (op_q == egm_pkg::OP_ENCRYPT) begin
						ob_q <= mrsp.prod;
					end else begin
						op8_q <= mrsp.prod[egm_pkg::BYTE_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign out_a     = oa_q;
	assign out_b     = ob_q;
	assign out_plain = op8_q;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == egm_pkg::ST_OUT) |=> out_valid)
		else $error("result lost");
	a_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == egm_pkg::ST_IDLE)
		else $error("transfer taken while busy");
	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.start |-> !mrsp.busy)
		else $error("multiplier restarted while busy");

endmodule
